// ===== rtl/wvr_pkg.sv =====
// ----------------------------------------------------------------------------
// wvr_pkg
// Shared types, codes and defaults for the wavetable voice renderer: item and
// play-mode codes, register indexes, controller states and the command and
// status groups between the controller and the datapath.
// ----------------------------------------------------------------------------
`default_nettype none

package wvr_pkg;

    // Default build values
    localparam int SAMPLE_DEPTH_DEF  = 4096;
    localparam int OUTPUT_OFFSET_DEF = 0;

    // Field widths fixed by the interface
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 32;

    // Item operation codes
    localparam logic [1:0] OP_WRITE  = 2'd0;
    localparam logic [1:0] OP_KEY_ON = 2'd1;
    localparam logic [1:0] OP_RENDER = 2'd2;

    // Play modes
    localparam logic [1:0] MODE_OFF    = 2'd0;
    localparam logic [1:0] MODE_SINGLE = 2'd1;
    localparam logic [1:0] MODE_LOOP   = 2'd2;

    // Register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_START_MODE    = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_PHASE_STEP    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_SAMPLE_LENGTH = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_LOOP_START    = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_LOOP_END      = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_MAIN_VOLUME   = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_LEFT_VOLUME   = 3'd6;
    localparam logic [CFG_IDX_W-1:0] CFG_RIGHT_VOLUME  = 3'd7;

    // Controller states
    typedef enum logic [2:0] {
        S_IDLE,
        S_ADDR,
        S_ADDR_DIV,
        S_EXEC,
        S_MUL,
        S_CHECK,
        S_WRAP_DIV,
        S_FIN
    } t_wvr_state;

    // Commands from the controller to the datapath
    typedef struct packed {
        logic capture;     // take the accepted input word
        logic div_start;   // launch the remainder unit
        logic div_wrap;    // 1: loop wrap operands, 0: address operands
        logic mem_wr;      // write the sample memory
        logic mem_rd;      // read the sample memory
        logic key_on;      // clear phase, load play mode
        logic mul_step;    // scale sample, advance phase
        logic check;       // single-shot end and plain loop wrap
        logic wrap_apply;  // load wrapped index from the remainder
        logic out_load;    // load the output word
        logic out_played;  // output word comes from a playing voice
    } t_wvr_cmd;

    // Status from the datapath to the controller
    typedef struct packed {
        logic [1:0] op;
        logic       voice_off;
        logic       addr_div_needed;
        logic       wrap_div_needed;
        logic       div_done;
    } t_wvr_stat;

endpackage

`default_nettype wire

// ===== rtl/wavetable_voice_render_top.sv =====
// A render word gives its result in the output word; a sample write or key-on
// completes without one. The next word is taken the cycle after one completes.
// A word passes through the shared 16-step remainder unit once for a loop wrap
// out of the region, and once per memory access when SAMPLE_DEPTH is not a
// power of two. A render word waits while the output word is still stalled.
// Reset (synchronous, active low) clears registers, phase, play mode and output
// valid; the sample memory holds no reset value and reads as written.
// ----------------------------------------------------------------------------
// wavetable_voice_render_top
// One wavetable voice: sample memory, 16.16 phase, stereo volume scaling and
// single-shot or looped playback behind valid/ready word channels.
// ----------------------------------------------------------------------------
`default_nettype none

module wavetable_voice_render_top #(
    parameter int SAMPLE_DEPTH  = wvr_pkg::SAMPLE_DEPTH_DEF,
    parameter int OUTPUT_OFFSET = wvr_pkg::OUTPUT_OFFSET_DEF
) (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    // register port
    input  wire logic                            i_cfg_wr_en,
    input  wire logic [wvr_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  wire logic [wvr_pkg::CFG_DATA_W-1:0]  i_cfg_data,
    // input channel
    input  wire logic                            i_in_valid,
    output logic                                 o_in_ready,
    input  wire logic [1:0]                      i_operation,
    input  wire logic [11:0]                     i_sample_address,
    input  wire logic signed [7:0]               i_sample_value,
    input  wire logic                            i_stamp,
    input  wire logic signed [15:0]              i_mix_left,
    input  wire logic signed [15:0]              i_mix_right,
    // output channel
    output logic                                 o_out_valid,
    input  wire logic                            i_out_ready,
    output logic signed [15:0]                   o_left_out,
    output logic signed [15:0]                   o_right_out,
    output logic                                 o_voice_active
);

    wvr_pkg::t_wvr_cmd  cmd;
    wvr_pkg::t_wvr_stat stat;

    wvr_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .i_stat      (stat),
        .o_cmd       (cmd)
    );

    wvr_datapath #(
        .SAMPLE_DEPTH  (SAMPLE_DEPTH),
        .OUTPUT_OFFSET (OUTPUT_OFFSET)
    ) u_dp (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cfg_wr_en      (i_cfg_wr_en),
        .i_cfg_index      (i_cfg_index),
        .i_cfg_data       (i_cfg_data),
        .i_operation      (i_operation),
        .i_sample_address (i_sample_address),
        .i_sample_value   (i_sample_value),
        .i_stamp          (i_stamp),
        .i_mix_left       (i_mix_left),
        .i_mix_right      (i_mix_right),
        .i_cmd            (cmd),
        .o_stat           (stat),
        .o_left_out       (o_left_out),
        .o_right_out      (o_right_out),
        .o_voice_active   (o_voice_active)
    );

endmodule

`default_nettype wire

// ===== rtl/wvr_rem_unit.sv =====
// ----------------------------------------------------------------------------
// wvr_rem_unit
// Restoring remainder unit: a 16-bit dividend over a 17-bit divisor, one
// quotient bit per cycle; done is high for a single cycle with the final remainder.
// ----------------------------------------------------------------------------
`default_nettype none

module wvr_rem_unit (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_start,
    input  wire logic [15:0] i_dividend,
    input  wire logic [16:0] i_divisor,
    output logic             o_done,
    output logic [16:0]      o_rem
);

    logic [16:0] r_rem;
    logic [15:0] r_dvd;
    logic [16:0] r_dvs;
    logic [4:0]  r_cnt;
    logic        r_busy;
    logic        r_done;

    logic [17:0] trial;
    logic [17:0] diff;

    // Shift in the next dividend bit and try the subtraction
    always_comb begin
        trial = {r_rem, r_dvd[15]};
        diff  = trial - {1'b0, r_dvs};
    end

    // Control: busy flag, bit counter, done pulse
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= 5'd16;
            end else if (r_busy) begin
                r_cnt <= r_cnt - 5'd1;
                if (r_cnt == 5'd1) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // Datapath: partial remainder and shifting dividend
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= '0;
            r_dvd <= i_dividend;
            r_dvs <= i_divisor;
        end else if (r_busy) begin
            r_dvd <= {r_dvd[14:0], 1'b0};
            if (trial >= {1'b0, r_dvs}) begin
                r_rem <= diff[16:0];
            end else begin
                r_rem <= trial[16:0];
            end
        end
    end

    assign o_done = r_done;
    assign o_rem  = r_rem;

endmodule

`default_nettype wire

// ===== rtl/wvr_datapath.sv =====
// ----------------------------------------------------------------------------
// wvr_datapath
// Voice datapath: registers, sample memory, phase accumulator, play mode,
// volume scaling, loop wrap arithmetic and the output word.
// ----------------------------------------------------------------------------
`default_nettype none

module wvr_datapath #(
    parameter int SAMPLE_DEPTH  = wvr_pkg::SAMPLE_DEPTH_DEF,
    parameter int OUTPUT_OFFSET = wvr_pkg::OUTPUT_OFFSET_DEF
) (
    input  wire logic                             i_clk,
    input  wire logic                             i_rst_n,
    // register port
    input  wire logic                             i_cfg_wr_en,
    input  wire logic [wvr_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  wire logic [wvr_pkg::CFG_DATA_W-1:0]   i_cfg_data,
    // input word
    input  wire logic [1:0]                       i_operation,
    input  wire logic [11:0]                      i_sample_address,
    input  wire logic signed [7:0]                i_sample_value,
    input  wire logic                             i_stamp,
    input  wire logic signed [15:0]               i_mix_left,
    input  wire logic signed [15:0]               i_mix_right,
    // controller link
    input  wire wvr_pkg::t_wvr_cmd                i_cmd,
    output wvr_pkg::t_wvr_stat                    o_stat,
    // output word
    output logic signed [15:0]                    o_left_out,
    output logic signed [15:0]                    o_right_out,
    output logic                                  o_voice_active
);

    localparam int          AW        = $clog2(SAMPLE_DEPTH);
    localparam bit          ADDR_POW2 = ((SAMPLE_DEPTH & (SAMPLE_DEPTH - 1)) == 0);
    localparam logic [16:0] DEPTH_W   = 17'(SAMPLE_DEPTH);
    localparam logic [15:0] OFFSET_W  = 16'(OUTPUT_OFFSET);

    // Registers
    logic [1:0]         r_start_mode;
    logic [31:0]        r_step;
    logic [12:0]        r_len;
    logic [11:0]        r_lstart;
    logic [12:0]        r_lend;
    logic signed [7:0]  r_main;
    logic signed [7:0]  r_lvol;
    logic signed [7:0]  r_rvol;

    // Captured input word
    logic [1:0]         r_op;
    logic [11:0]        r_addr;
    logic [7:0]         r_wval;
    logic               r_stamp;
    logic [15:0]        r_mixl;
    logic [15:0]        r_mixr;

    // Voice state
    logic [31:0]        r_phase;
    logic [1:0]         r_mode;

    // Arithmetic pipeline
    logic signed [7:0]  r_scale_l;
    logic signed [7:0]  r_scale_r;
    logic signed [7:0]  r_sample;
    logic signed [15:0] r_pl;
    logic signed [15:0] r_pr;

    // Output word
    logic [15:0]        r_left;
    logic [15:0]        r_right;
    logic               r_active;

    // Sample memory
    logic [7:0]         mem [SAMPLE_DEPTH];

    logic signed [15:0] ear_l;
    logic signed [15:0] ear_r;
    logic [15:0]        base16;
    logic [AW-1:0]      mem_addr;
    logic [15:0]        idx;
    logic               step_neg;
    logic               idx_ge_len;
    logic               out_region;
    logic               region_empty;
    logic [12:0]        loop_len;
    logic [15:0]        div_dividend;
    logic [16:0]        div_divisor;
    logic               div_done;
    logic [16:0]        div_rem;
    logic [15:0]        wrap_idx;
    logic               single_end;
    logic [15:0]        n_left;
    logic [15:0]        n_right;

    // Ear scales: high byte of main times ear volume
    always_comb begin
        ear_l = r_main * r_lvol;
        ear_r = r_main * r_rvol;
    end

    always_ff @(posedge i_clk) begin
        r_scale_l <= ear_l[15:8];
        r_scale_r <= ear_r[15:8];
    end

    // Memory address: write address or play index, reduced to the depth
    always_comb begin
        base16 = (r_op == wvr_pkg::OP_WRITE) ? {4'd0, r_addr} : r_phase[31:16];
        if (ADDR_POW2) begin
            mem_addr = base16[AW-1:0];
        end else begin
            mem_addr = div_rem[AW-1:0];
        end
    end

    // Index checks after the step
    always_comb begin
        idx          = r_phase[31:16];
        step_neg     = r_step[31];
        idx_ge_len   = idx >= {3'd0, r_len};
        region_empty = r_lend <= {1'b0, r_lstart};
        loop_len     = r_lend - {1'b0, r_lstart};
        if (step_neg) begin
            out_region = idx < {4'd0, r_lstart};
        end else begin
            out_region = idx >= {3'd0, r_lend};
        end
        single_end = (r_mode == wvr_pkg::MODE_SINGLE) && idx_ge_len;
    end

    // Remainder operands: address reduction or loop wrap distance
    always_comb begin
        if (i_cmd.div_wrap) begin
            if (step_neg) begin
                div_dividend = {4'd0, r_lstart} - 16'd1 - idx;
            end else begin
                div_dividend = idx - {4'd0, r_lstart};
            end
            div_divisor = {4'd0, loop_len};
        end else begin
            div_dividend = base16;
            div_divisor  = DEPTH_W;
        end
    end

    wvr_rem_unit u_rem (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (i_cmd.div_start),
        .i_dividend (div_dividend),
        .i_divisor  (div_divisor),
        .o_done     (div_done),
        .o_rem      (div_rem)
    );

    // Wrapped index from the remainder
    always_comb begin
        if (step_neg) begin
            wrap_idx = {4'd0, r_lstart} + {3'd0, loop_len} - 16'd1 - div_rem[15:0];
        end else begin
            wrap_idx = {4'd0, r_lstart} + div_rem[15:0];
        end
    end

    // Register writes; single-shot end clears the step
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_start_mode <= '0;
            r_step       <= '0;
            r_len        <= '0;
            r_lstart     <= '0;
            r_lend       <= '0;
            r_main       <= '0;
            r_lvol       <= '0;
            r_rvol       <= '0;
        end else if (i_cfg_wr_en) begin
            case (i_cfg_index)
                wvr_pkg::CFG_START_MODE:    r_start_mode <= i_cfg_data[1:0];
                wvr_pkg::CFG_PHASE_STEP:    r_step       <= i_cfg_data;
                wvr_pkg::CFG_SAMPLE_LENGTH: r_len        <= i_cfg_data[12:0];
                wvr_pkg::CFG_LOOP_START:    r_lstart     <= i_cfg_data[11:0];
                wvr_pkg::CFG_LOOP_END:      r_lend       <= i_cfg_data[12:0];
                wvr_pkg::CFG_MAIN_VOLUME:   r_main       <= i_cfg_data[7:0];
                wvr_pkg::CFG_LEFT_VOLUME:   r_lvol       <= i_cfg_data[7:0];
                wvr_pkg::CFG_RIGHT_VOLUME:  r_rvol       <= i_cfg_data[7:0];
                default: ;
            endcase
        end else if (i_cmd.check && single_end) begin
            r_step <= '0;
        end
    end

    // Capture the accepted word
    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_op    <= i_operation;
            r_addr  <= i_sample_address;
            r_wval  <= i_sample_value;
            r_stamp <= i_stamp;
            r_mixl  <= i_mix_left;
            r_mixr  <= i_mix_right;
        end
    end

    // Sample memory: one port, registered read
    always_ff @(posedge i_clk) begin
        if (i_cmd.mem_wr) begin
            mem[mem_addr] <= r_wval;
        end
        if (i_cmd.mem_rd) begin
            r_sample <= mem[mem_addr];
        end
    end

    // Scale the sample per ear
    always_ff @(posedge i_clk) begin
        if (i_cmd.mul_step) begin
            r_pl <= r_sample * r_scale_l;
            r_pr <= r_sample * r_scale_r;
        end
    end

    // Phase accumulator and play mode
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= '0;
            r_mode  <= wvr_pkg::MODE_OFF;
        end else if (i_cmd.key_on) begin
            r_phase <= '0;
            if (r_start_mode == wvr_pkg::MODE_SINGLE || r_start_mode == wvr_pkg::MODE_LOOP) begin
                r_mode <= r_start_mode;
            end else begin
                r_mode <= wvr_pkg::MODE_OFF;
            end
        end else if (i_cmd.mul_step) begin
            r_phase <= r_phase + r_step;
        end else if (i_cmd.check) begin
            if (single_end) begin
                r_mode <= wvr_pkg::MODE_OFF;
            end else if (r_mode == wvr_pkg::MODE_LOOP && out_region && region_empty) begin
                r_phase[31:16] <= {4'd0, r_lstart};
            end
        end else if (i_cmd.wrap_apply) begin
            r_phase[31:16] <= wrap_idx;
        end
    end

    // Output word: stamp or accumulate; when silent, the offset or the mix alone
    always_comb begin
        if (i_cmd.out_played) begin
            n_left  = r_stamp ? (r_pl + OFFSET_W) : (r_mixl + r_pl);
            n_right = r_stamp ? (r_pr + OFFSET_W) : (r_mixr + r_pr);
        end else begin
            n_left  = r_stamp ? OFFSET_W : r_mixl;
            n_right = r_stamp ? OFFSET_W : r_mixr;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            r_left   <= n_left;
            r_right  <= n_right;
            r_active <= (r_mode != wvr_pkg::MODE_OFF);
        end
    end

    // Status to the controller
    always_comb begin
        o_stat.op              = r_op;
        o_stat.voice_off       = (r_mode == wvr_pkg::MODE_OFF);
        o_stat.addr_div_needed = !ADDR_POW2 &&
                                 ((r_op == wvr_pkg::OP_WRITE) ||
                                  ((r_op == wvr_pkg::OP_RENDER) &&
                                   (r_mode != wvr_pkg::MODE_OFF)));
        o_stat.wrap_div_needed = (r_mode == wvr_pkg::MODE_LOOP) && out_region &&
                                 !region_empty;
        o_stat.div_done        = div_done;
    end

    assign o_left_out     = r_left;
    assign o_right_out    = r_right;
    assign o_voice_active = r_active;

endmodule

`default_nettype wire

// ===== rtl/wvr_ctrl.sv =====
// ----------------------------------------------------------------------------
// wvr_ctrl
// Voice controller: takes one word at a time, steps the datapath through
// address reduction, memory access, scaling, phase advance and loop wrap,
// and owns the output valid flag.
// ----------------------------------------------------------------------------
`default_nettype none

module wvr_ctrl (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                i_in_valid,
    output logic                     o_in_ready,
    output logic                     o_out_valid,
    input  wire logic                i_out_ready,
    input  wire wvr_pkg::t_wvr_stat  i_stat,
    output wvr_pkg::t_wvr_cmd        o_cmd
);

    wvr_pkg::t_wvr_state r_state;
    wvr_pkg::t_wvr_state n_state;
    logic                r_out_valid;
    logic                n_out_valid;
    logic                out_free;

    assign out_free = !r_out_valid || i_out_ready;

    // State and output valid registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= wvr_pkg::S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    // Next state and commands
    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        case (r_state)
            wvr_pkg::S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.capture = 1'b1;
                    n_state       = wvr_pkg::S_ADDR;
                end
            end
            wvr_pkg::S_ADDR: begin
                if (i_stat.addr_div_needed) begin
                    o_cmd.div_start = 1'b1;
                    n_state         = wvr_pkg::S_ADDR_DIV;
                end else begin
                    n_state = wvr_pkg::S_EXEC;
                end
            end
            wvr_pkg::S_ADDR_DIV: begin
                if (i_stat.div_done) begin
                    n_state = wvr_pkg::S_EXEC;
                end
            end
            wvr_pkg::S_EXEC: begin
                case (i_stat.op)
                    wvr_pkg::OP_WRITE: begin
                        o_cmd.mem_wr = 1'b1;
                        n_state      = wvr_pkg::S_IDLE;
                    end
                    wvr_pkg::OP_KEY_ON: begin
                        o_cmd.key_on = 1'b1;
                        n_state      = wvr_pkg::S_IDLE;
                    end
                    wvr_pkg::OP_RENDER: begin
                        if (!i_stat.voice_off) begin
                            o_cmd.mem_rd = 1'b1;
                            n_state      = wvr_pkg::S_MUL;
                        end else if (out_free) begin
                            // silent voice: hold until the output word is free
                            o_cmd.out_load = 1'b1;
                            n_state        = wvr_pkg::S_IDLE;
                        end
                    end
                    default: begin
                        n_state = wvr_pkg::S_IDLE;
                    end
                endcase
            end
            wvr_pkg::S_MUL: begin
                o_cmd.mul_step = 1'b1;
                n_state        = wvr_pkg::S_CHECK;
            end
            wvr_pkg::S_CHECK: begin
                o_cmd.check = 1'b1;
                if (i_stat.wrap_div_needed) begin
                    o_cmd.div_start = 1'b1;
                    o_cmd.div_wrap  = 1'b1;
                    n_state         = wvr_pkg::S_WRAP_DIV;
                end else begin
                    n_state = wvr_pkg::S_FIN;
                end
            end
            wvr_pkg::S_WRAP_DIV: begin
                o_cmd.div_wrap = 1'b1;
                if (i_stat.div_done) begin
                    o_cmd.wrap_apply = 1'b1;
                    n_state          = wvr_pkg::S_FIN;
                end
            end
            wvr_pkg::S_FIN: begin
                o_cmd.out_played = 1'b1;
                if (out_free) begin
                    o_cmd.out_load = 1'b1;
                    n_state        = wvr_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = wvr_pkg::S_IDLE;
            end
        endcase
    end

    // Output valid: set on load, drop once taken
    always_comb begin
        if (o_cmd.out_load) begin
            n_out_valid = 1'b1;
        end else if (i_out_ready) begin
            n_out_valid = 1'b0;
        end else begin
            n_out_valid = r_out_valid;
        end
    end

    assign o_in_ready  = (r_state == wvr_pkg::S_IDLE);
    assign o_out_valid = r_out_valid;

endmodule

`default_nettype wire

// ===== rtl/wvr_checker.sv =====
// ----------------------------------------------------------------------------
// wvr_checker
// Port-level checks on the voice: output word handshake and the one-word-at-a-
// time acceptance of the input channel.
// ----------------------------------------------------------------------------
`default_nettype none

module wvr_checker (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_in_valid,
    input  wire logic        i_in_ready,
    input  wire logic        i_out_valid,
    input  wire logic        i_out_ready,
    input  wire logic [15:0] i_left_out,
    input  wire logic [15:0] i_right_out
);

    // A stalled output word stays valid
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid)
        else $error("output word dropped while stalled");

    // A stalled output word keeps its payload
    a_out_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> $stable(i_left_out) && $stable(i_right_out))
        else $error("output payload changed while stalled");

    // After taking a word the block is not ready in the next cycle
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && i_in_ready |=> !i_in_ready)
        else $error("input taken again straight after acceptance");

    // A new output word only appears at the end of work on an input word
    a_out_from_work: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(i_out_valid) |-> $past(!i_in_ready))
        else $error("output word raised while idle");

endmodule

bind wavetable_voice_render_top wvr_checker u_wvr_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_valid),
    .i_in_ready  (o_in_ready),
    .i_out_valid (o_out_valid),
    .i_out_ready (i_out_ready),
    .i_left_out  (o_left_out),
    .i_right_out (o_right_out)
);

`default_nettype wire
